// File: hw/rtl/ktae_pkg.sv
// Shared types and constants for the keyed table with aging and eviction.
// Holds the command and result beat layouts plus the FSM state type.
// No dependencies.
`timescale 1ns / 1ps

package ktae_pkg;

    localparam int NUM_ENTRIES_DEF  = 16;
    localparam int PAYLOAD_BITS_DEF = 64;
    localparam int PAYLOAD_MAX      = 64;

    localparam logic [31:0] STALE_LIMIT_RST = 32'd1000;
    localparam logic [4:0]  MAX_RESULTS     = 5'd16;

    localparam logic [1:0] CMD_UPSERT = 2'd0;
    localparam logic [1:0] CMD_SWEEP  = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    typedef enum logic [1:0] {
        OP_UPSERT = 2'd0,
        OP_SWEEP  = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ACT_UPDATED    = 3'd0,
        ACT_INSERTED   = 3'd1,
        ACT_REPLACED   = 3'd2,
        ACT_SWEPT      = 3'd3,
        ACT_READ_ENTRY = 3'd4,
        ACT_READ_NONE  = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_EVAL,
        ST_FINISH,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_op                    op;
        logic [31:0]            key;
        logic [31:0]            ts;
        logic [PAYLOAD_MAX-1:0] payload;
        logic [31:0]            now;
        logic [4:0]             limit;
    } t_cmd;

    typedef struct packed {
        t_action                action;
        logic [3:0]             slot;
        logic [31:0]            id;
        logic [31:0]            ts;
        logic [PAYLOAD_MAX-1:0] payload;
        logic [4:0]             removed;
        logic [4:0]             valid_cnt;
        logic                   last;
    } t_result;

endpackage

// File: hw/rtl/ktae_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ktae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/ktae_fifo.sv
// Small flop-based FIFO used for the command queue and the result queue.
// No dependencies; a push when full or a pop when empty is ignored.
`timescale 1ns / 1ps

module ktae_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rptr];
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

// File: hw/rtl/ktae_front.sv
// Front end: takes input beats, decodes the command and queues known ones.
// Depends on ktae_pkg and ktae_fifo.
`timescale 1ns / 1ps

module ktae_front #(
    parameter int PAYLOAD_BITS = ktae_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [1:0]              i_command,
    input  logic [31:0]             i_peer_id,
    input  logic [31:0]             i_peer_timestamp,
    input  logic [PAYLOAD_BITS-1:0] i_peer_payload,
    input  logic [31:0]             i_now_time,
    input  logic [4:0]              i_read_limit,
    output ktae_pkg::t_cmd          o_cmd,
    output logic                    o_cmd_empty,
    input  logic                    i_cmd_pop
);

    import ktae_pkg::*;

    t_cmd             cmd_in;
    logic             known;
    logic [$bits(t_cmd)-1:0] q_rdata;

    // Unused command code is accepted and dropped here.
    assign known = (i_command inside {CMD_UPSERT, CMD_SWEEP, CMD_READ});

    always_comb begin
        cmd_in         = '0;
        cmd_in.op      = t_op'(i_command);
        cmd_in.key     = i_peer_id;
        cmd_in.ts      = i_peer_timestamp;
        cmd_in.payload = PAYLOAD_MAX'(i_peer_payload);
        cmd_in.now     = i_now_time;
        cmd_in.limit   = i_read_limit;
    end

    ktae_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && known),
        .i_wdata (cmd_in),
        .i_pop   (i_cmd_pop),
        .o_rdata (q_rdata),
        .o_full  (full),
        .o_empty (o_cmd_empty)
    );

    assign o_cmd = t_cmd'(q_rdata);

endmodule

// File: hw/rtl/ktae_back.sv
// Back end: scan sequencer over the entry RAM, valid bits and valid count.
// Depends on ktae_pkg and ktae_ram.
`timescale 1ns / 1ps

module ktae_back #(
    parameter int NUM_ENTRIES  = ktae_pkg::NUM_ENTRIES_DEF,
    parameter int PAYLOAD_BITS = ktae_pkg::PAYLOAD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ktae_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    input  logic [31:0]       i_stale_limit,
    output ktae_pkg::t_result o_res,
    output logic              o_res_push,
    input  logic              i_res_full
);

    import ktae_pkg::*;

    localparam int SLOT_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CUR_W  = SLOT_W + 1;
    localparam int CNT_W  = $clog2(NUM_ENTRIES + 1);
    localparam int ROW_W  = 64 + PAYLOAD_BITS;

    t_state                 r_state, n_state;
    t_cmd                   r_cmd;
    logic [CUR_W-1:0]       r_cur;
    logic [SLOT_W-1:0]      r_idx;
    logic [4:0]             r_cnt;
    logic [CNT_W-1:0]       r_removed;
    logic                   r_match;
    logic [SLOT_W-1:0]      r_match_idx;
    logic [31:0]            r_min_time;
    logic [SLOT_W-1:0]      r_min_idx;
    logic [NUM_ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]       r_valid_cnt;
    t_result                r_res;

    logic                   nv_found;
    logic [SLOT_W-1:0]      nv_idx;
    logic                   free_found;
    logic [SLOT_W-1:0]      free_idx;
    logic                   above_any;
    logic [4:0]             lim;
    logic                   read_full;
    logic [ROW_W-1:0]       ram_q;
    logic [31:0]            rd_key, rd_time;
    logic [PAYLOAD_BITS-1:0] rd_data;
    logic                   key_hit, stale, inserted;
    logic [31:0]            age;
    logic [SLOT_W-1:0]      tgt;
    logic                   ram_we;
    t_result                eval_res, fin_res;

    assign rd_key  = ram_q[ROW_W-1 -: 32];
    assign rd_time = ram_q[ROW_W-33 -: 32];
    assign rd_data = ram_q[PAYLOAD_BITS-1:0];

    // Lowest valid slot at or after the cursor, lowest free slot, and
    // whether any valid slot lies beyond the one being read.
    always_comb begin
        nv_found   = 1'b0;
        nv_idx     = '0;
        free_found = 1'b0;
        free_idx   = '0;
        above_any  = 1'b0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (CUR_W'(i) >= r_cur)) begin
                nv_found = 1'b1;
                nv_idx   = SLOT_W'(i);
            end
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
            if (r_valid[i] && (SLOT_W'(i) > r_idx)) begin
                above_any = 1'b1;
            end
        end
    end

    assign lim       = (r_cmd.limit > MAX_RESULTS) ? MAX_RESULTS : r_cmd.limit;
    assign read_full = (r_cmd.op == OP_READ) && (r_cnt == lim);
    assign key_hit   = (rd_key == r_cmd.key);
    assign age       = r_cmd.now - rd_time;
    assign stale     = (age > i_stale_limit);
    assign inserted  = !r_match && free_found;
    assign tgt       = r_match ? r_match_idx : (free_found ? free_idx : r_min_idx);

    ktae_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_ENTRIES)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (tgt),
        .i_wdata ({r_cmd.key, r_cmd.ts, PAYLOAD_BITS'(r_cmd.payload)}),
        .i_raddr (nv_idx),
        .o_rdata (ram_q)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                n_state = (nv_found && !read_full) ? ST_EVAL : ST_FINISH;
            end
            ST_EVAL: begin
                case (r_cmd.op)
                    OP_UPSERT: n_state = key_hit ? ST_FINISH : ST_ISSUE;
                    OP_READ:   n_state = ST_EMIT;
                    default:   n_state = ST_ISSUE;
                endcase
            end
            ST_FINISH: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_res_full) begin
                    n_state = r_res.last ? ST_IDLE : ST_ISSUE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        ram_we     = 1'b0;
        case (r_state)
            ST_IDLE:   o_cmd_pop  = !i_cmd_empty;
            ST_FINISH: ram_we     = (r_cmd.op == OP_UPSERT);
            ST_EMIT:   o_res_push = !i_res_full;
            default: begin
            end
        endcase
    end

    always_comb begin
        eval_res           = '0;
        eval_res.action    = ACT_READ_ENTRY;
        eval_res.slot      = 4'(r_idx);
        eval_res.id        = rd_key;
        eval_res.ts        = rd_time;
        eval_res.payload   = PAYLOAD_MAX'(rd_data);
        eval_res.valid_cnt = 5'(r_valid_cnt);
        eval_res.last      = ((r_cnt + 5'd1) == lim) || !above_any;
    end

    always_comb begin
        fin_res      = '0;
        fin_res.last = 1'b1;
        case (r_cmd.op)
            OP_UPSERT: begin
                fin_res.action    = r_match ? ACT_UPDATED :
                                    (free_found ? ACT_INSERTED : ACT_REPLACED);
                fin_res.slot      = 4'(tgt);
                fin_res.valid_cnt = 5'(r_valid_cnt + CNT_W'(inserted));
            end
            OP_SWEEP: begin
                fin_res.action    = ACT_SWEPT;
                fin_res.removed   = 5'(r_removed);
                fin_res.valid_cnt = 5'(r_valid_cnt);
            end
            default: begin
                fin_res.action    = ACT_READ_NONE;
                fin_res.valid_cnt = 5'(r_valid_cnt);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_valid_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_EVAL && r_cmd.op == OP_SWEEP && stale) begin
                r_valid[r_idx] <= 1'b0;
                r_valid_cnt    <= r_valid_cnt - 1'b1;
            end
            if (ram_we) begin
                r_valid[tgt] <= 1'b1;
                if (inserted) begin
                    r_valid_cnt <= r_valid_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_cmd       <= i_cmd;
                r_cur       <= '0;
                r_idx       <= '0;
                r_cnt       <= '0;
                r_removed   <= '0;
                r_match     <= 1'b0;
                r_match_idx <= '0;
                r_min_time  <= '1;
                r_min_idx   <= '0;
            end
            ST_ISSUE: begin
                r_idx <= nv_idx;
                r_cur <= CUR_W'(nv_idx) + 1'b1;
            end
            ST_EVAL: begin
                case (r_cmd.op)
                    OP_UPSERT: begin
                        if (key_hit) begin
                            r_match     <= 1'b1;
                            r_match_idx <= r_idx;
                        end else if (rd_time < r_min_time) begin
                            r_min_time <= rd_time;
                            r_min_idx  <= r_idx;
                        end
                    end
                    OP_SWEEP: begin
                        if (stale) begin
                            r_removed <= r_removed + 1'b1;
                        end
                    end
                    default: begin
                        r_res <= eval_res;
                        r_cnt <= r_cnt + 5'd1;
                    end
                endcase
            end
            ST_FINISH: begin
                r_res <= fin_res;
            end
            default: begin
            end
        endcase
    end

    assign o_res = r_res;

endmodule

// File: hw/rtl/keyed_table_with_aging_and_eviction_core.sv
// Keyed table: front decode queue, back scan sequencer, result queue.
// Upsert and sweep visit at most every valid slot, each through ISSUE and
// EVAL with the registered RAM read between; a read passes each returned
// beat through EMIT. One item is worked at a time; the queues absorb stalls.
// Reset clears all valid bits and the count at once and loads the stale
// limit with 1000; entry contents are not cleared and need no sweep.
`timescale 1ns / 1ps

module keyed_table_with_aging_and_eviction_core #(
    parameter int NUM_ENTRIES  = ktae_pkg::NUM_ENTRIES_DEF,
    parameter int PAYLOAD_BITS = ktae_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [31:0]             i_cfg_wdata,
    input  logic                    push,
    output logic                    full,
    input  logic [1:0]              i_command,
    input  logic [31:0]             i_peer_id,
    input  logic [31:0]             i_peer_timestamp,
    input  logic [PAYLOAD_BITS-1:0] i_peer_payload,
    input  logic [31:0]             i_now_time,
    input  logic [4:0]              i_read_limit,
    output logic                    empty,
    input  logic                    pop,
    output logic [2:0]              o_action,
    output logic [3:0]              o_slot,
    output logic [31:0]             o_out_id,
    output logic [31:0]             o_out_timestamp,
    output logic [PAYLOAD_BITS-1:0] o_out_payload,
    output logic [4:0]              o_removed_count,
    output logic [4:0]              o_valid_count,
    output logic                    o_last
);

    import ktae_pkg::*;

    logic [31:0] r_stale_limit;
    t_cmd        cmd;
    logic        cmd_empty, cmd_pop;
    t_result     res_in, res_out;
    logic        res_push, res_full;
    logic [$bits(t_result)-1:0] res_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale_limit <= STALE_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_stale_limit <= i_cfg_wdata;
        end
    end

    ktae_front #(
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_command        (i_command),
        .i_peer_id        (i_peer_id),
        .i_peer_timestamp (i_peer_timestamp),
        .i_peer_payload   (i_peer_payload),
        .i_now_time       (i_now_time),
        .i_read_limit     (i_read_limit),
        .o_cmd            (cmd),
        .o_cmd_empty      (cmd_empty),
        .i_cmd_pop        (cmd_pop)
    );

    ktae_back #(
        .NUM_ENTRIES  (NUM_ENTRIES),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cmd_empty   (cmd_empty),
        .o_cmd_pop     (cmd_pop),
        .i_stale_limit (r_stale_limit),
        .o_res         (res_in),
        .o_res_push    (res_push),
        .i_res_full    (res_full)
    );

    ktae_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_in),
        .i_pop   (pop),
        .o_rdata (res_q),
        .o_full  (res_full),
        .o_empty (empty)
    );

    assign res_out         = t_result'(res_q);
    assign o_action        = res_out.action;
    assign o_slot          = res_out.slot;
    assign o_out_id        = res_out.id;
    assign o_out_timestamp = res_out.ts;
    assign o_out_payload   = PAYLOAD_BITS'(res_out.payload);
    assign o_removed_count = res_out.removed;
    assign o_valid_count   = res_out.valid_cnt;
    assign o_last          = res_out.last;

endmodule

// File: hw/rtl/ktae_checker.sv
// Port-level checks on the result side of the keyed table, bound to the top.
// Depends on ktae_pkg.
`timescale 1ns / 1ps

module ktae_checker #(
    parameter int NUM_ENTRIES = ktae_pkg::NUM_ENTRIES_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic [2:0]  o_action,
    input logic [31:0] o_out_id,
    input logic [31:0] o_out_timestamp,
    input logic [4:0]  o_removed_count,
    input logic [4:0]  o_valid_count,
    input logic        o_last
);

    import ktae_pkg::*;

    // Nothing is left to deliver right after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((NUM_ENTRIES >= 32) || (o_valid_count <= 5'(NUM_ENTRIES))))
        else $error("valid count above table size");

    // Only read beats carry entry contents; all others end their command.
    a_non_read_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_action != ACT_READ_ENTRY)) |->
            (o_out_id == 32'd0 && o_out_timestamp == 32'd0 && o_last))
        else $error("non-read beat carries entry data or lacks last");

    a_removed_only_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_action != ACT_SWEPT)) |-> (o_removed_count == 5'd0))
        else $error("removed count set outside a sweep");

endmodule

bind keyed_table_with_aging_and_eviction_core ktae_checker #(
    .NUM_ENTRIES (NUM_ENTRIES)
) u_ktae_checker (.*);
